[src/triangle_altitudes_and_centroid_defines.svh]
// Assertion macros for the triangle altitude block checker.
`ifndef TRIANGLE_ALTITUDES_AND_CENTROID_DEFINES_SVH
`define TRIANGLE_ALTITUDES_AND_CENTROID_DEFINES_SVH

// same-cycle implication
`define TAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tac_pkg.sv]
// Widths and constants of the triangle altitude and centroid pipeline.
package tac_pkg;

    localparam int COORD_W  = 24;
    localparam int DIFF_W   = COORD_W + 1;      // vertex difference
    localparam int SUM_W    = COORD_W + 2;      // sum of three coordinates
    localparam int PROD_W   = 2 * DIFF_W;       // product of two differences
    localparam int SQR_W    = 2 * COORD_W;      // square of one difference
    localparam int SIDE_W   = 2 * COORD_W + 2;  // squared side length
    localparam int CROSS_W  = 2 * COORD_W + 1;  // |cross product component|
    localparam int LO_W     = DIFF_W;           // low half of a cross component
    localparam int HI_W     = CROSS_W - LO_W;   // high half
    localparam int SQ_W     = 2 * CROSS_W;      // squared cross component
    localparam int C2_W     = SQ_W + 2;         // (2*area)^2
    localparam int QUO_W    = 2 * COORD_W;      // quotient bits before the root
    localparam int ROOT_W   = COORD_W;
    localparam int SREM_W   = COORD_W + 3;      // root remainder

    // x/3 = (x * DIV3_MUL) >> DIV3_SH, exact for x < 2^DIFF_W
    localparam int DIV3_SH  = DIFF_W + 1;
    localparam logic [DIFF_W-1:0] DIV3_MUL = DIFF_W'(((64'd1 << DIV3_SH) + 64'd2) / 64'd3);

    localparam int FRONT_LAT = 7;
    localparam int LANE_LAT  = 1 + QUO_W + ROOT_W;
    localparam int PIPE      = FRONT_LAT + LANE_LAT;

    localparam int IN_W  = 9 * COORD_W;
    localparam int OUT_W = 6 * COORD_W;

endpackage

[src/tac_alt_lane.sv]
// One altitude lane: saturation check, restoring divide, then digit-by-digit square root.
module tac_alt_lane (
    input  logic                         clk,
    input  logic                         en,
    input  logic [tac_pkg::C2_W-1:0]     c2,
    input  logic [tac_pkg::SIDE_W-1:0]   s2,
    output logic [tac_pkg::COORD_W-1:0]  alt
);
    import tac_pkg::*;

    logic [C2_W-1:0]   drem_reg [0:QUO_W-1];
    logic [SIDE_W-1:0] ds2_reg  [0:QUO_W-1];
    logic [QUO_W-1:0]  dq_reg   [0:QUO_W];
    logic              dsat_reg [0:QUO_W];

    logic [QUO_W-1:0]  rq_in    [0:ROOT_W-1];
    logic [SREM_W-1:0] rrem_in  [0:ROOT_W-1];
    logic [ROOT_W-1:0] rroot_in [0:ROOT_W-1];
    logic              rsat_in  [0:ROOT_W-1];

    logic [QUO_W-1:0]  rq_reg    [0:ROOT_W-2];
    logic [SREM_W-1:0] rrem_reg  [0:ROOT_W-2];
    logic [ROOT_W-1:0] rroot_reg [0:ROOT_W-2];
    logic              rsat_reg  [0:ROOT_W-2];
    logic [ROOT_W-1:0] alt_reg;

    // zero side or quotient of 2^(2*COORD_W) or more gives the maximum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            drem_reg[0] <= c2;
            ds2_reg[0]  <= s2;
            dq_reg[0]   <= '0;
            dsat_reg[0] <= (s2 == '0) || (c2 >= C2_W'({s2, {QUO_W{1'b0}}}));
        end
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        localparam int B = QUO_W - 1 - k;
        logic [C2_W-1:0] dsub;
        logic [C2_W:0]   ddiff;
        logic            ge;

        assign dsub  = C2_W'(ds2_reg[k]) << B;
        assign ddiff = {1'b0, drem_reg[k]} - {1'b0, dsub};
        assign ge    = !ddiff[C2_W];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dq_reg[k+1]   <= dq_reg[k] | (ge ? (QUO_W'(1) << B) : '0);
                dsat_reg[k+1] <= dsat_reg[k];
            end
        end

        if (k < QUO_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    drem_reg[k+1] <= ge ? ddiff[C2_W-1:0] : drem_reg[k];
                    ds2_reg[k+1]  <= ds2_reg[k];
                end
            end
        end
    end

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_sqrt
        localparam int I = ROOT_W - 1 - j;
        logic [SREM_W-1:0] cur;
        logic [SREM_W-1:0] trial;
        logic [SREM_W:0]   sdiff;
        logic              ge;
        logic [SREM_W-1:0] rem_next;
        logic [ROOT_W-1:0] root_next;

        if (j == 0)
        begin : g_src_div
            assign rq_in[j]    = dq_reg[QUO_W];
            assign rrem_in[j]  = '0;
            assign rroot_in[j] = '0;
            assign rsat_in[j]  = dsat_reg[QUO_W];
        end
        else
        begin : g_src_reg
            assign rq_in[j]    = rq_reg[j-1];
            assign rrem_in[j]  = rrem_reg[j-1];
            assign rroot_in[j] = rroot_reg[j-1];
            assign rsat_in[j]  = rsat_reg[j-1];
        end

        assign cur       = {rrem_in[j][SREM_W-3:0], rq_in[j][2*I +: 2]};
        assign trial     = SREM_W'({rroot_in[j], 2'b01});
        assign sdiff     = {1'b0, cur} - {1'b0, trial};
        assign ge        = !sdiff[SREM_W];
        assign rem_next  = ge ? sdiff[SREM_W-1:0] : cur;
        assign root_next = {rroot_in[j][ROOT_W-2:0], ge};

        if (j < ROOT_W - 1)
        begin : g_step
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rq_reg[j]    <= rq_in[j];
                    rrem_reg[j]  <= rem_next;
                    rroot_reg[j] <= root_next;
                    rsat_reg[j]  <= rsat_in[j];
                end
            end
        end
        else
        begin : g_last
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    alt_reg <= rsat_in[j] ? '1 : root_next;
                end
            end
        end
    end

    assign alt = alt_reg;

endmodule

[src/triangle_altitudes_and_centroid.sv]
// Top level of the triangle altitude and centroid pipeline.
// Takes one triangle per clock when not stalled (three 3-D vertices, signed fixed point)
// and returns the three altitudes, 2*area over each side, floored and saturated to all
// ones, the centroid truncated toward zero, and a flag for a zero-length side. The
// pipeline is 80 register stages deep and takes a new beat every cycle while s_tready is
// high: seven stages form the squared sides and the squared doubled area, one lane per
// side then spends one stage on the saturation check, 48 stages on a bit-per-stage divide
// and 24 on a digit-per-stage square root. The last lane stage feeds a two-entry output
// stage (output register plus skid) that lets the pipeline keep moving under output
// backpressure until a valid beat has to go into the skid; s_tready drops the cycle after
// and the whole pipeline then holds.
module triangle_altitudes_and_centroid (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z
    input  logic [tac_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // alt_a, alt_b, alt_c, mid_x, mid_y, mid_z
    output logic [tac_pkg::OUT_W-1:0]   m_tdata,
    // degenerate
    output logic [0:0]                  m_tuser
);
    import tac_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] mid_x;
        logic signed [COORD_W-1:0] mid_y;
        logic signed [COORD_W-1:0] mid_z;
        logic                      deg;
    } side_t;

    typedef struct packed {
        logic [COORD_W-1:0] alt_a;
        logic [COORD_W-1:0] alt_b;
        logic [COORD_W-1:0] alt_c;
        side_t              side;
    } res_t;

    logic en;
    logic [PIPE-1:0] v_reg;

    logic signed [COORD_W-1:0] pin [3][3];

    // A: edge vectors (0: p1-p0, 1: p2-p1, 2: p0-p2) and coordinate sums
    logic signed [DIFF_W-1:0] a_d_reg   [3][3];
    logic signed [SUM_W-1:0]  a_sum_reg [3];
    // B: products
    logic signed [PROD_W-1:0] sq_full   [3][3];
    logic signed [PROD_W-1:0] b_cp_reg  [6];
    logic [SQR_W-1:0]         b_sq_reg  [3][3];
    logic [DIFF_W-1:0]        b_cabs_reg[3];
    logic                     b_cneg_reg[3];
    // C
    logic signed [PROD_W-1:0] c_td_reg   [3];
    logic [SIDE_W-1:0]        c_s2_reg   [3];
    logic [PROD_W-1:0]        c_cprod_reg[3];
    logic                     c_cneg_reg [3];
    // D
    logic [CROSS_W-1:0]       d_tabs_reg[3];
    logic [SIDE_W-1:0]        d_s2_reg  [3];
    side_t                    d_side_reg;
    // E
    logic [2*HI_W-1:0]        e_hh_reg[3];
    logic [HI_W+LO_W-1:0]     e_hl_reg[3];
    logic [2*LO_W-1:0]        e_ll_reg[3];
    logic [SIDE_W-1:0]        e_s2_reg[3];
    side_t                    e_side_reg;
    // F
    logic [SQ_W-1:0]          f_tsq_reg[3];
    logic [SIDE_W-1:0]        f_s2_reg [3];
    side_t                    f_side_reg;
    // G
    logic [C2_W-1:0]          g_c2_reg;
    logic [SIDE_W-1:0]        g_s2_reg[3];
    side_t                    g_side_reg;

    side_t                    side_reg[0:LANE_LAT-1];
    logic [COORD_W-1:0]       alt[3];

    res_t pipe_res;
    res_t out_reg;
    res_t skid_reg;
    logic ov_reg;
    logic sv_reg;
    logic o_free;

    assign en       = !sv_reg;
    assign s_tready = en;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pin[i][k] = s_tdata[(3*i+k)*COORD_W +: COORD_W];
            end
        end
    end

    always_comb
    begin
        for (int s = 0; s < 3; s++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_full[s][k] = a_d_reg[s][k] * a_d_reg[s][k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[PIPE-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a_d_reg[0][k] <= DIFF_W'(pin[1][k]) - DIFF_W'(pin[0][k]);
                a_d_reg[1][k] <= DIFF_W'(pin[2][k]) - DIFF_W'(pin[1][k]);
                a_d_reg[2][k] <= DIFF_W'(pin[0][k]) - DIFF_W'(pin[2][k]);
                a_sum_reg[k]  <= SUM_W'(pin[0][k]) + SUM_W'(pin[1][k]) + SUM_W'(pin[2][k]);
            end

            // cross product u x v as pairs of products
            b_cp_reg[0] <= a_d_reg[0][1] * a_d_reg[1][2];
            b_cp_reg[1] <= a_d_reg[0][2] * a_d_reg[1][1];
            b_cp_reg[2] <= a_d_reg[0][2] * a_d_reg[1][0];
            b_cp_reg[3] <= a_d_reg[0][0] * a_d_reg[1][2];
            b_cp_reg[4] <= a_d_reg[0][0] * a_d_reg[1][1];
            b_cp_reg[5] <= a_d_reg[0][1] * a_d_reg[1][0];
            for (int s = 0; s < 3; s++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    b_sq_reg[s][k] <= sq_full[s][k][SQR_W-1:0];
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                b_cabs_reg[k] <= a_sum_reg[k][SUM_W-1] ? DIFF_W'(-a_sum_reg[k])
                                                       : DIFF_W'(a_sum_reg[k]);
                b_cneg_reg[k] <= a_sum_reg[k][SUM_W-1];
            end

            for (int j = 0; j < 3; j++)
            begin
                c_td_reg[j]    <= b_cp_reg[2*j] - b_cp_reg[2*j+1];
                c_s2_reg[j]    <= SIDE_W'(b_sq_reg[j][0]) + SIDE_W'(b_sq_reg[j][1])
                                + SIDE_W'(b_sq_reg[j][2]);
                c_cprod_reg[j] <= b_cabs_reg[j] * DIV3_MUL;
                c_cneg_reg[j]  <= b_cneg_reg[j];
            end

            for (int j = 0; j < 3; j++)
            begin
                d_tabs_reg[j] <= c_td_reg[j][PROD_W-1] ? CROSS_W'(-c_td_reg[j])
                                                       : CROSS_W'(c_td_reg[j]);
                d_s2_reg[j]   <= c_s2_reg[j];
            end
            d_side_reg.mid_x <= c_cneg_reg[0] ? -c_cprod_reg[0][DIV3_SH +: COORD_W]
                                              : c_cprod_reg[0][DIV3_SH +: COORD_W];
            d_side_reg.mid_y <= c_cneg_reg[1] ? -c_cprod_reg[1][DIV3_SH +: COORD_W]
                                              : c_cprod_reg[1][DIV3_SH +: COORD_W];
            d_side_reg.mid_z <= c_cneg_reg[2] ? -c_cprod_reg[2][DIV3_SH +: COORD_W]
                                              : c_cprod_reg[2][DIV3_SH +: COORD_W];
            d_side_reg.deg   <= (c_s2_reg[0] == '0) || (c_s2_reg[1] == '0)
                             || (c_s2_reg[2] == '0);

            // square of each cross component from its halves
            for (int j = 0; j < 3; j++)
            begin
                e_hh_reg[j] <= d_tabs_reg[j][CROSS_W-1 -: HI_W] * d_tabs_reg[j][CROSS_W-1 -: HI_W];
                e_hl_reg[j] <= d_tabs_reg[j][CROSS_W-1 -: HI_W] * d_tabs_reg[j][LO_W-1:0];
                e_ll_reg[j] <= d_tabs_reg[j][LO_W-1:0] * d_tabs_reg[j][LO_W-1:0];
                e_s2_reg[j] <= d_s2_reg[j];
            end
            e_side_reg <= d_side_reg;

            for (int j = 0; j < 3; j++)
            begin
                f_tsq_reg[j] <= (SQ_W'(e_hh_reg[j]) << (2*LO_W))
                              + (SQ_W'(e_hl_reg[j]) << (LO_W+1))
                              + SQ_W'(e_ll_reg[j]);
                f_s2_reg[j]  <= e_s2_reg[j];
            end
            f_side_reg <= e_side_reg;

            g_c2_reg   <= C2_W'(f_tsq_reg[0]) + C2_W'(f_tsq_reg[1]) + C2_W'(f_tsq_reg[2]);
            g_s2_reg   <= f_s2_reg;
            g_side_reg <= f_side_reg;

            side_reg[0] <= g_side_reg;
            for (int i = 1; i < LANE_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    for (genvar s = 0; s < 3; s++)
    begin : g_lane
        tac_alt_lane u_lane (
            .clk (clk),
            .en  (en),
            .c2  (g_c2_reg),
            .s2  (g_s2_reg[s]),
            .alt (alt[s])
        );
    end

    always_comb
    begin
        pipe_res.alt_a = alt[0];
        pipe_res.alt_b = alt[1];
        pipe_res.alt_c = alt[2];
        pipe_res.side  = side_reg[LANE_LAT-1];
    end

    assign o_free = !ov_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else if (sv_reg)
        begin
            if (o_free)
            begin
                ov_reg <= 1'b1;
                sv_reg <= 1'b0;
            end
        end
        else if (o_free)
        begin
            ov_reg <= v_reg[PIPE-1];
        end
        else if (v_reg[PIPE-1])
        begin
            sv_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sv_reg)
        begin
            if (o_free)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (o_free)
        begin
            out_reg <= pipe_res;
        end
        else
        begin
            skid_reg <= pipe_res;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {out_reg.side.mid_z, out_reg.side.mid_y, out_reg.side.mid_x,
                       out_reg.alt_c, out_reg.alt_b, out_reg.alt_a};
    assign m_tuser  = out_reg.side.deg;

endmodule

[src/tac_checker.sv]
// Port-level checks of the triangle altitude block, bound to the top level.
`include "triangle_altitudes_and_centroid_defines.svh"

module tac_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tready,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [tac_pkg::OUT_W-1:0]  m_tdata,
    input  logic [0:0]                 m_tuser
);
    import tac_pkg::*;

    logic alt_any_max;

    assign alt_any_max = (m_tdata[0 +: COORD_W] == '1)
                      || (m_tdata[COORD_W +: COORD_W] == '1)
                      || (m_tdata[2*COORD_W +: COORD_W] == '1);

    // the input only stalls after a beat was held at the output
    `TAC_ASSERT_NOW(a_stall_cause, clk, rst_n, !s_tready, $past(m_tvalid && !m_tready), "input stalled with no output backpressure")

    `TAC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output beat changed while stalled")

    // a zero-length side always saturates its own altitude
    `TAC_ASSERT_NOW(a_deg_sat, clk, rst_n, m_tvalid && m_tuser[0], alt_any_max, "degenerate beat without a saturated altitude")

endmodule

bind triangle_altitudes_and_centroid tac_checker u_tac_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[bench/testbench.sv]
// Testbench for the triangle altitude and centroid pipeline.
`timescale 1ns / 100ps

module testbench;
    import tac_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] alt_a;
        logic [COORD_W-1:0] alt_b;
        logic [COORD_W-1:0] alt_c;
        logic [COORD_W-1:0] mid_x;
        logic [COORD_W-1:0] mid_y;
        logic [COORD_W-1:0] mid_z;
        logic               degenerate;
    } tri_result_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic [0:0]          m_tuser;

    tri_result_t         expected_q[$];
    int                  fail_count;
    int                  hold_cycles;
    int                  burst_left;

    localparam logic [COORD_W-1:0] SAT = {COORD_W{1'b1}};
    localparam int MAXPOS = (1 << (COORD_W - 1)) - 1;
    localparam int MINNEG = -(1 << (COORD_W - 1));

    triangle_altitudes_and_centroid u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // floor(sqrt(x)) for x below 2^(2*COORD_W+2)
    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] side_altitude(input logic [255:0] area2,
                                                         input logic [255:0] side2);
        logic [255:0] q;
        logic [63:0]  r;
        if (side2 == 0)
            return SAT;
        if (area2 >= (side2 << (2 * COORD_W)))
            return SAT;
        q = area2 / side2;
        r = int_sqrt(q[63:0]);
        return (r > SAT) ? SAT : r[COORD_W-1:0];
    endfunction

    function automatic tri_result_t triangle_expect(input logic [IN_W-1:0] data);
        longint       p[3][3];
        longint       u[3], v[3], w[3];
        logic signed [255:0] cx, cy, cz;
        logic [255:0] sa, sb, sc, c2;
        tri_result_t  r;
        longint       mean;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                p[i][k] = longint'($signed(data[(i*3+k)*COORD_W +: COORD_W]));
        for (int k = 0; k < 3; k++)
        begin
            u[k] = p[1][k] - p[0][k];
            v[k] = p[2][k] - p[1][k];
            w[k] = p[0][k] - p[2][k];
        end
        sa = 0; sb = 0; sc = 0;
        for (int k = 0; k < 3; k++)
        begin
            sa += 256'(u[k] * u[k]);
            sb += 256'(v[k] * v[k]);
            sc += 256'(w[k] * w[k]);
        end
        cx = 256'(u[1] * v[2]) - 256'(u[2] * v[1]);
        cy = 256'(u[2] * v[0]) - 256'(u[0] * v[2]);
        cz = 256'(u[0] * v[1]) - 256'(u[1] * v[0]);
        c2 = cx * cx + cy * cy + cz * cz;
        r.alt_a = side_altitude(c2, sa);
        r.alt_b = side_altitude(c2, sb);
        r.alt_c = side_altitude(c2, sc);
        mean = (p[0][0] + p[1][0] + p[2][0]) / 3;
        r.mid_x = mean[COORD_W-1:0];
        mean = (p[0][1] + p[1][1] + p[2][1]) / 3;
        r.mid_y = mean[COORD_W-1:0];
        mean = (p[0][2] + p[1][2] + p[2][2]) / 3;
        r.mid_z = mean[COORD_W-1:0];
        r.degenerate = (sa == 0) || (sb == 0) || (sc == 0);
        return r;
    endfunction

    task automatic send_triangle(input logic [IN_W-1:0] data);
        // bursty sender: random gaps between bursts
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_q.insert(expected_q.size(), triangle_expect(data));
        burst_left--;
    endtask

    task automatic finish_sending();
        s_tvalid <= 1'b0;
    endtask

    function automatic logic [IN_W-1:0] pack_tri(input int c[9]);
        logic [IN_W-1:0] d;
        for (int i = 0; i < 9; i++)
            d[i*COORD_W +: COORD_W] = c[i][COORD_W-1:0];
        return d;
    endfunction

    function automatic int rand_coord(input int span);
        int m;
        case ($urandom_range(0, 3))
            0: return int'($urandom_range(0, 2 * span)) - span;
            1: return int'($urandom_range(0, 2000)) - 1000;
            2: return $urandom_range(0, 1) ? MAXPOS - int'($urandom_range(0, 15))
                                          : MINNEG + int'($urandom_range(0, 15));
            default:
            begin
                m = $urandom;
                return int'({{(32-COORD_W){m[COORD_W-1]}}, m[COORD_W-1:0]});
            end
        endcase
    endfunction

    task automatic test_directed();
        int c[9];
        c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_triangle(pack_tri(c));                                   // all points coincide
        c = '{0, 0, 0, 256, 0, 0, 0, 256, 0};
        send_triangle(pack_tri(c));                                   // unit right triangle
        c = '{0, 0, 0, 256, 0, 0, 256, 0, 0};
        send_triangle(pack_tri(c));                                   // p1 == p2
        c = '{5, 6, 7, 5, 6, 7, 100, 3, 9};
        send_triangle(pack_tri(c));                                   // p0 == p1
        c = '{0, 0, 0, 100, 100, 100, 200, 200, 200};
        send_triangle(pack_tri(c));                                   // collinear
        c = '{MAXPOS, MAXPOS, MAXPOS, MINNEG, MINNEG, MINNEG, MAXPOS, MINNEG, MAXPOS};
        send_triangle(pack_tri(c));
        c = '{MINNEG, MAXPOS, 0, MAXPOS, MINNEG, 0, MINNEG, MINNEG, MAXPOS};
        send_triangle(pack_tri(c));
        c = '{MINNEG, MINNEG, MINNEG, MINNEG, MINNEG, MINNEG, MINNEG, MINNEG, MINNEG};
        send_triangle(pack_tri(c));
        c = '{-1, -1, -1, -2, -1, -1, -1, -2, -1};
        send_triangle(pack_tri(c));                                   // negative centroid
        c = '{MINNEG, 0, 0, MAXPOS, 0, 0, 0, 1, 0};
        send_triangle(pack_tri(c));                                   // long flat triangle
        c = '{MINNEG, 0, 0, MAXPOS, 0, 0, 0, MAXPOS, 0};
        send_triangle(pack_tri(c));                                   // huge area
        c = '{0, 0, 0, 1, 0, 0, 0, MAXPOS, 0};
        send_triangle(pack_tri(c));                                   // tall altitude over a side of length 1
        c = '{-7, 3, -2, -7, 3, -2, -7, 3, -2};
        send_triangle(pack_tri(c));
        finish_sending();
    endtask

    task automatic test_random(input int count, input int span);
        int c[9];
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 9; i++)
                c[i] = rand_coord(span);
            // some degenerate triangles with random content
            if ($urandom_range(0, 19) == 0)
                for (int k = 0; k < 3; k++)
                    c[3 + k] = c[k];
            send_triangle(pack_tri(c));
        end
        finish_sending();
    endtask

    task automatic test_backpressure();
        int c[9];
        hold_cycles = 200;
        for (int n = 0; n < 120; n++)
        begin
            for (int i = 0; i < 9; i++)
                c[i] = rand_coord(4096);
            burst_left = 100;
            send_triangle(pack_tri(c));
        end
        finish_sending();
    endtask

    task automatic drain_results();
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // receiver: stall pattern plus long hold-off on request
    initial
    begin
        int phase;
        m_tready <= 1'b0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                phase = (phase + 1) % 64;
                if (phase < 16)
                    m_tready <= 1'b1;
                else
                    m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        tri_result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[0 +: COORD_W], m_tdata[COORD_W +: COORD_W],
                   m_tdata[2*COORD_W +: COORD_W], m_tdata[3*COORD_W +: COORD_W],
                   m_tdata[4*COORD_W +: COORD_W], m_tdata[5*COORD_W +: COORD_W],
                   m_tuser[0]};
            if (expected_q.size() == 0)
            begin
                $error("unexpected result beat %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.alt_a !== want.alt_a)
                begin
                    $error("alt_a expected %h got %h", want.alt_a, got.alt_a);
                    fail_count++;
                end
                if (got.alt_b !== want.alt_b)
                begin
                    $error("alt_b expected %h got %h", want.alt_b, got.alt_b);
                    fail_count++;
                end
                if (got.alt_c !== want.alt_c)
                begin
                    $error("alt_c expected %h got %h", want.alt_c, got.alt_c);
                    fail_count++;
                end
                if (got.mid_x !== want.mid_x)
                begin
                    $error("mid_x expected %h got %h", want.mid_x, got.mid_x);
                    fail_count++;
                end
                if (got.mid_y !== want.mid_y)
                begin
                    $error("mid_y expected %h got %h", want.mid_y, got.mid_y);
                    fail_count++;
                end
                if (got.mid_z !== want.mid_z)
                begin
                    $error("mid_z expected %h got %h", want.mid_z, got.mid_z);
                    fail_count++;
                end
                if (got.degenerate !== want.degenerate)
                begin
                    $error("degenerate expected %b got %b", want.degenerate,
                           got.degenerate);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        fail_count  = 0;
        hold_cycles = 0;
        burst_left  = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        drain_results();
        test_backpressure();
        drain_results();
        test_random(700, 2048);
        drain_results();                 // sender pause until all results are back
        test_random(800, MAXPOS);
        drain_results();
        repeat (PIPE + 20) @(posedge clk);

        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

[triangle_altitudes_and_centroid.f]
+incdir+src
src/tac_pkg.sv
src/tac_alt_lane.sv
src/triangle_altitudes_and_centroid.sv
src/tac_checker.sv
bench/testbench.sv
